### rtl/afv_pkg.sv
// ----------------------------------------------------------------------------
// afv_pkg
// Shared types and constants for the box versus frustum visibility test.
// ----------------------------------------------------------------------------
`default_nettype none

package afv_pkg;

   localparam int NUM_PLANES = 6;
   localparam int WORD_BITS  = 32;

   localparam int DATA_W    = 32;
   localparam int COEF_NUM  = 4;
   localparam int PLANE_AW  = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int W_SHIFT   = 16;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      COEF_X = 2'd0,
      COEF_Y = 2'd1,
      COEF_Z = 2'd2,
      COEF_W = 2'd3
   } coef_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_MUL_W,
      ST_SUM,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         store_wr;
      logic         box_load;
      logic         plane_clr;
      logic         plane_inc;
      logic         rd_en;
      logic         prod_en;
      coef_sel_type sel;
      logic         acc_clr;
      logic         acc_add;
      logic         vis_init;
      logic         vis_check;
      logic         rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic last_plane;
   } dp_status_type;

   // Low WORD_BITS bits read as two's complement, extended to the full word.
   function automatic logic signed [DATA_W-1:0] sext_word(input logic [DATA_W-1:0] v);
      return DATA_W'($signed(v[WORD_BITS-1:0]));
   endfunction

endpackage

`default_nettype wire

### rtl/afv_ram.sv
// ----------------------------------------------------------------------------
// afv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module afv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/afv_dp.sv
// ----------------------------------------------------------------------------
// afv_dp
// Datapath: plane coefficient store, box registers, shared multiplier,
// exact accumulator and visibility flag.
// ----------------------------------------------------------------------------
`default_nettype none

module afv_dp
   import afv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             status,
   input  wire logic [2:0]           req_plane_index,
   input  wire logic [1:0]           req_coeff_index,
   input  wire logic signed [31:0]   req_coeff_value,
   input  wire logic signed [31:0]   req_box_min_x,
   input  wire logic signed [31:0]   req_box_min_y,
   input  wire logic signed [31:0]   req_box_min_z,
   input  wire logic signed [31:0]   req_box_max_x,
   input  wire logic signed [31:0]   req_box_max_y,
   input  wire logic signed [31:0]   req_box_max_z,
   output logic                      rsp_visible
);

   localparam logic [3:0] PLANE_LIMIT = 4'(NUM_PLANES);

   logic [PLANE_AW-1:0]      plane_ff, plane_in;
   logic [DATA_W-1:0]        coef_rd [COEF_NUM];
   logic                     wr_ok;
   logic [PLANE_AW-1:0]      wr_addr;

   logic signed [DATA_W-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic signed [DATA_W-1:0] max_x_ff, max_y_ff, max_z_ff;

   logic signed [DATA_W-1:0] n_sel;
   logic signed [DATA_W-1:0] corner_sel;
   logic                     n_pos;
   logic signed [PROD_W-1:0] mul_res;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     vis_ff, vis_in;
   logic                     rsp_visible_ff;

   assign wr_ok   = cmd.store_wr && ({1'b0, req_plane_index} < PLANE_LIMIT);
   assign wr_addr = req_plane_index[PLANE_AW-1:0];

   for (genvar k = 0; k < COEF_NUM; k++) begin : g_coef
      afv_ram #(
         .WIDTH (DATA_W),
         .DEPTH (NUM_PLANES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_ok && (req_coeff_index == 2'(k))),
         .wr_addr (wr_addr),
         .wr_data (req_coeff_value),
         .rd_en   (cmd.rd_en),
         .rd_addr (plane_ff),
         .rd_data (coef_rd[k])
      );
   end

   always_comb begin
      plane_in = plane_ff;
      if (cmd.plane_clr) begin
         plane_in = '0;
      end else if (cmd.plane_inc) begin
         plane_in = plane_ff + PLANE_AW'(1);
      end
   end

   assign status.last_plane = (plane_ff == PLANE_AW'(NUM_PLANES - 1));

   // p-vertex: max coordinate on a positive normal component, min otherwise
   assign n_sel = sext_word(coef_rd[cmd.sel]);
   assign n_pos = !n_sel[DATA_W-1] && (|n_sel);

   always_comb begin
      unique case (cmd.sel)
         COEF_X:  corner_sel = n_pos ? max_x_ff : min_x_ff;
         COEF_Y:  corner_sel = n_pos ? max_y_ff : min_y_ff;
         COEF_Z:  corner_sel = n_pos ? max_z_ff : min_z_ff;
         default: corner_sel = '0;
      endcase
   end

   assign mul_res = n_sel * corner_sel;

   always_comb begin
      if (cmd.sel == COEF_W) begin
         prod_in = {{(PROD_W - DATA_W - W_SHIFT){n_sel[DATA_W-1]}}, n_sel, W_SHIFT'(0)};
      end else begin
         prod_in = mul_res;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_comb begin
      vis_in = vis_ff;
      if (cmd.vis_init) begin
         vis_in = 1'b1;
      end else if (cmd.vis_check && acc_ff[ACC_W-1]) begin
         vis_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.box_load) begin
         min_x_ff <= sext_word(req_box_min_x);
         min_y_ff <= sext_word(req_box_min_y);
         min_z_ff <= sext_word(req_box_min_z);
         max_x_ff <= sext_word(req_box_max_x);
         max_y_ff <= sext_word(req_box_max_y);
         max_z_ff <= sext_word(req_box_max_z);
      end
      if (cmd.prod_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.rsp_load) begin
         rsp_visible_ff <= vis_ff;
      end
      acc_ff <= acc_in;
      vis_ff <= vis_in;
   end

   assign rsp_visible = rsp_visible_ff;

endmodule

`default_nettype wire

### rtl/afv_ctrl.sv
// ----------------------------------------------------------------------------
// afv_ctrl
// Controller: accepts words, sequences the per-plane multiply-accumulate
// steps and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module afv_ctrl
   import afv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_opcode,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.sel      = COEF_X;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_opcode) == OP_TEST) begin
                  cmd.box_load  = 1'b1;
                  cmd.vis_init  = 1'b1;
                  cmd.plane_clr = 1'b1;
                  state_in      = ST_READ;
               end else begin
                  cmd.store_wr  = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.prod_en = 1'b1;
            cmd.sel     = COEF_X;
            cmd.acc_clr = 1'b1;
            state_in    = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.prod_en = 1'b1;
            cmd.sel     = COEF_Y;
            cmd.acc_add = 1'b1;
            state_in    = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            cmd.prod_en = 1'b1;
            cmd.sel     = COEF_Z;
            cmd.acc_add = 1'b1;
            state_in    = ST_MUL_W;
         end
         ST_MUL_W: begin
            cmd.prod_en = 1'b1;
            cmd.sel     = COEF_W;
            cmd.acc_add = 1'b1;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.vis_check = 1'b1;
            if (status.last_plane) begin
               state_in = ST_DONE;
            end else begin
               cmd.plane_inc = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/aabb_frustum_visibility_test.sv
// ----------------------------------------------------------------------------
// aabb_frustum_visibility_test
// Axis-aligned box versus six-plane frustum culling (p-vertex test).
// ----------------------------------------------------------------------------
// A load word (opcode 0) writes one Q16.16 plane coefficient and returns
// nothing; loads to a plane index past the last plane are dropped. A test
// word (opcode 1) returns one word, visible = 0 when the box lies fully
// behind some plane. Per plane, a test makes one read of the coefficient
// store, three passes through the single shared 32x32 multiplier, an offset
// step, a final add and a sign check. Sums are exact, no rounding or
// saturation. The input is held off while a test runs; loads are taken
// while a previous result still waits on the output register. All planes
// must be loaded before the first test.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_visibility_test
   import afv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [2:0]          req_plane_index,
   input  wire logic [1:0]          req_coeff_index,
   input  wire logic signed [31:0]  req_coeff_value,
   input  wire logic signed [31:0]  req_box_min_x,
   input  wire logic signed [31:0]  req_box_min_y,
   input  wire logic signed [31:0]  req_box_min_z,
   input  wire logic signed [31:0]  req_box_max_x,
   input  wire logic signed [31:0]  req_box_max_y,
   input  wire logic signed [31:0]  req_box_max_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_visible
);

   dp_cmd_type    cmd;
   dp_status_type status;

   afv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   afv_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_plane_index (req_plane_index),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .req_box_min_x   (req_box_min_x),
      .req_box_min_y   (req_box_min_y),
      .req_box_min_z   (req_box_min_z),
      .req_box_max_x   (req_box_max_x),
      .req_box_max_y   (req_box_max_y),
      .req_box_max_z   (req_box_max_z),
      .rsp_visible     (rsp_visible)
   );

endmodule

`default_nettype wire
